[design/tcfd_pkg.sv]
// tcfd_pkg: constants, codes and shared types for the text command frame decoder.
// Used by the interfaces and every module of the decoder; depends on nothing.
`default_nettype none

package tcfd_pkg;

  // Kept fraction digits; extra ones are checked and dropped.
  localparam int FRAC_DIGITS = 6;
  localparam int FRAC_CNT_W  = (FRAC_DIGITS > 7) ? 4 : 3;

  localparam int MANT_W  = 48;
  localparam int PROD_W  = MANT_W + 4;
  localparam int ID_W    = 24;
  localparam int POS_W   = 4;
  localparam int FRAC_W  = 3;

  // Largest magnitude the mantissa may hold: 2^47 - 1.
  localparam logic signed [PROD_W-1:0] MAG_LIMIT = PROD_W'(48'h7FFF_FFFF_FFFF);

  localparam logic [POS_W-1:0] POS_START = 4'd0;
  localparam logic [POS_W-1:0] POS_OP    = 4'd1;
  localparam logic [POS_W-1:0] POS_SEP   = 4'd2;
  localparam logic [POS_W-1:0] POS_ID0   = 4'd3;
  localparam logic [POS_W-1:0] POS_ID1   = 4'd4;
  localparam logic [POS_W-1:0] POS_ID2   = 4'd5;
  localparam logic [POS_W-1:0] POS_EQ    = 4'd6;
  localparam logic [POS_W-1:0] POS_READ_END = 4'd7;
  localparam logic [POS_W-1:0] POS_SIGN_OUT = 4'd9;
  localparam logic [POS_W-1:0] POS_MAX   = 4'd15;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_W      = 8'h77;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_P      = 8'h70;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_PRINT = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SYNTAX  = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  // One character handed to the value accumulator.
  typedef struct packed {
    logic       en;
    logic       clear;
    logic       at_seven;
    logic [7:0] ch;
  } val_step_t;

  typedef struct packed {
    logic signed [MANT_W-1:0] mant;
    logic [FRAC_CNT_W-1:0]    frac;
    logic                     minus;
    logic                     point;
    logic                     digit;
    logic                     bad;
    logic                     over;
  } val_state_t;

  typedef struct packed {
    status_t                  status;
    op_t                      operation;
    logic [ID_W-1:0]          param_id;
    logic signed [MANT_W-1:0] value_mantissa;
    logic [FRAC_W-1:0]        fraction_digits;
    logic                     has_point;
  } result_t;

endpackage

`default_nettype wire

[design/tcfd_ifs.sv]
// tcfd_byte_if and tcfd_result_if: valid/ready channels of the frame decoder.
// Depends on tcfd_pkg for field widths.
`default_nettype none

interface tcfd_byte_if;
  import tcfd_pkg::*;

  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface tcfd_result_if;
  import tcfd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [1:0]               operation;
  logic [ID_W-1:0]          param_id;
  logic signed [MANT_W-1:0] value_mantissa;
  logic [FRAC_W-1:0]        fraction_digits;
  logic                     has_point;

  modport source (output valid, status, operation, param_id, value_mantissa,
                  fraction_digits, has_point, input ready);
  modport sink   (input valid, status, operation, param_id, value_mantissa,
                  fraction_digits, has_point, output ready);
endinterface

`default_nettype wire

[design/tcfd_value_acc.sv]
// tcfd_value_acc: parses the value characters of a frame into a signed mantissa.
// Depends on tcfd_pkg; driven by tcfd_frame_parser.
`default_nettype none

module tcfd_value_acc (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tcfd_pkg::val_step_t step,
  output tcfd_pkg::val_state_t     nxt
);
  import tcfd_pkg::*;

  val_state_t cur;

  logic                     is_digit;
  logic [PROD_W-1:0]        d_ext;
  logic signed [PROD_W-1:0] m_ext;
  logic signed [PROD_W-1:0] prod;
  logic                     ovf;
  logic                     keep;

  assign is_digit = (step.ch >= CH_ZERO) && (step.ch <= CH_NINE);
  assign d_ext    = PROD_W'(step.ch - CH_ZERO);
  assign m_ext    = PROD_W'(cur.mant);

  // Minus can only come before the first digit, so accumulate with the sign.
  assign prod = (m_ext <<< 3) + (m_ext <<< 1) +
                (cur.minus ? -$signed(d_ext) : $signed(d_ext));
  assign ovf  = (prod > MAG_LIMIT) || (prod < -MAG_LIMIT);
  assign keep = !(cur.point && (cur.frac >= FRAC_CNT_W'(FRAC_DIGITS)));

  always_comb begin
    nxt = cur;
    if (step.en) begin
      if (step.at_seven && (step.ch == CH_MINUS)) begin
        nxt.minus = 1'b1;
      end else if (step.ch == CH_POINT) begin
        if (cur.point) begin
          nxt.bad = 1'b1;
        end
        nxt.point = 1'b1;
      end else if (!is_digit) begin
        nxt.bad = 1'b1;
      end else begin
        nxt.digit = 1'b1;
        if (keep) begin
          if (!cur.over) begin
            if (ovf) begin
              nxt.over = 1'b1;
            end else begin
              nxt.mant = prod[MANT_W-1:0];
            end
          end
          if (cur.point) begin
            nxt.frac = cur.frac + FRAC_CNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || step.clear) begin
      cur <= '0;
    end else begin
      cur <= nxt;
    end
  end

endmodule

`default_nettype wire

[design/tcfd_frame_parser.sv]
// tcfd_frame_parser: frame position, header checks, CR LF delay line and result.
// Depends on tcfd_pkg and tcfd_value_acc.
`default_nettype none

module tcfd_frame_parser (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            take,
  input  wire logic [7:0]      data_byte,
  input  wire logic            last_byte,
  output tcfd_pkg::result_t    res
);
  import tcfd_pkg::*;

  logic [POS_W-1:0] pos;
  logic [7:0]       dly0;
  logic [7:0]       dly1;
  op_t              op;
  logic [ID_W-1:0]  id;
  logic             syn_fail;

  op_t              op_next;
  logic [ID_W-1:0]  id_next;
  logic             syn_fail_next;

  val_step_t        step;
  val_state_t       val;
  logic             syn;
  logic             num_bad;

  // The byte two back feeds the value parser, so CR LF never reaches it.
  assign step = '{en:       take && (pos >= POS_SIGN_OUT),
                  clear:    take && last_byte,
                  at_seven: (pos == POS_SIGN_OUT),
                  ch:       dly1};

  tcfd_value_acc u_value_acc (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .nxt  (val)
  );

  always_comb begin
    op_next       = op;
    id_next       = id;
    syn_fail_next = syn_fail;
    case (pos)
      POS_START: begin
        if (data_byte != CH_BSLASH) syn_fail_next = 1'b1;
      end
      POS_OP: begin
        if (data_byte == CH_W) begin
          op_next = OP_WRITE;
        end else if (data_byte == CH_R) begin
          op_next = OP_READ;
        end else if (data_byte == CH_P) begin
          op_next = OP_PRINT;
        end else begin
          syn_fail_next = 1'b1;
        end
      end
      POS_SEP: begin
        if (data_byte != CH_USCORE) syn_fail_next = 1'b1;
      end
      POS_ID0, POS_ID1, POS_ID2: begin
        id_next = {id[ID_W-9:0], data_byte};
      end
      POS_EQ: begin
        if ((op != OP_READ) && (data_byte != CH_EQ)) syn_fail_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Header bytes all sit below the shortest legal end, so registered state is final here.
  always_comb begin
    syn = syn_fail || (pos < POS_READ_END) || (dly0 != CH_CR) || (data_byte != CH_LF);
    if (op == OP_READ) begin
      syn = syn || (pos != POS_READ_END);
    end else begin
      syn = syn || (pos < POS_SIGN_OUT);
    end
    num_bad = val.bad || val.over || !val.digit;

    res = '0;
    if (syn) begin
      res.status = ST_SYNTAX;
    end else if (op == OP_READ) begin
      res.status    = ST_OK;
      res.operation = op;
      res.param_id  = id;
    end else if (num_bad) begin
      res.status = ST_INVALID;
    end else begin
      res.status          = ST_OK;
      res.operation       = op;
      res.param_id        = id;
      res.value_mantissa  = val.mant;
      res.fraction_digits = val.frac[FRAC_W-1:0];
      res.has_point       = val.point;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (take && last_byte)) begin
      pos      <= '0;
      dly0     <= '0;
      dly1     <= '0;
      op       <= OP_WRITE;
      id       <= '0;
      syn_fail <= 1'b0;
    end else if (take) begin
      if (pos != POS_MAX) begin
        pos <= pos + POS_W'(1);
      end
      dly0     <= data_byte;
      dly1     <= dly0;
      op       <= op_next;
      id       <= id_next;
      syn_fail <= syn_fail_next;
    end
  end

endmodule

`default_nettype wire

[design/text_command_frame_decoder.sv]
// text_command_frame_decoder: one ASCII command frame in, one decoded result out.
// A byte is held in the input register and decoded from there into the result
// register; a last byte waits there while the result is still offered and not taken.
// Throughput: one byte per cycle, set by the single decode step per byte, while
// no last byte waits on a full result slot.
// Reset (rst, synchronous): empties both registers and returns to the start of a frame.
`default_nettype none

module text_command_frame_decoder (
  input  wire logic clk,
  input  wire logic rst,
  tcfd_byte_if.sink     cmd,
  tcfd_result_if.source rsp
);
  import tcfd_pkg::*;

  logic       in_vld;
  logic [7:0] in_data;
  logic       in_last;
  logic       adv;

  logic       out_vld;
  result_t    out_res;
  result_t    dec_res;

  // Non-last bytes produce nothing, so only a last byte waits on the result slot.
  assign adv       = in_vld && (!in_last || !out_vld || rsp.ready);
  assign cmd.ready = !in_vld || adv;

  tcfd_frame_parser u_frame_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (adv),
    .data_byte (in_data),
    .last_byte (in_last),
    .res       (dec_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      in_vld <= 1'b1;
    end else if (adv) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_data <= cmd.data_byte;
      in_last <= cmd.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv && in_last) begin
      out_vld <= 1'b1;
    end else if (rsp.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_last) begin
      out_res <= dec_res;
    end
  end

  assign rsp.valid           = out_vld;
  assign rsp.status          = out_res.status;
  assign rsp.operation       = out_res.operation;
  assign rsp.param_id        = out_res.param_id;
  assign rsp.value_mantissa  = out_res.value_mantissa;
  assign rsp.fraction_digits = out_res.fraction_digits;
  assign rsp.has_point       = out_res.has_point;

endmodule

`default_nettype wire

[dv/tb_text_command_frame_decoder.sv]
// Testbench for text_command_frame_decoder: drives command frames byte by byte and
// checks each decoded result against a frame decoder kept in a scoreboard class.
// Depends on tcfd_pkg, the channel interfaces in tcfd_ifs.sv and the decoder RTL.
`timescale 1ns / 1ps

module tb_text_command_frame_decoder;
  import tcfd_pkg::*;

  localparam int          TOTAL_BYTES = 950;
  localparam int          STALL_LIMIT = 1000;
  localparam int          IDLE_PCT    = 18;
  localparam logic [63:0] MAG_MAX     = 64'h7FFF_FFFF_FFFF;

  class frame_decode_model;
    logic [3:0]  pos;
    logic [7:0]  held_new;
    logic [7:0]  held_old;
    op_t         op;
    logic [23:0] id;
    logic [63:0] mag;
    int          frac;
    bit          f_minus, f_point, f_digit, f_bad, f_over;
    bit          hdr_bad;
    result_t     expected_decodes[$];
    int          mismatch_count;

    function new();
      mismatch_count = 0;
      clear();
    endfunction

    function void clear();
      pos      = POS_START;
      held_new = '0;
      held_old = '0;
      op       = OP_WRITE;
      id       = '0;
      mag      = '0;
      frac     = 0;
      f_minus  = 0;
      f_point  = 0;
      f_digit  = 0;
      f_bad    = 0;
      f_over   = 0;
      hdr_bad  = 0;
    endfunction

    function void take_value_char(logic [7:0] c, bit at_seven);
      logic [63:0] nxt;
      if (at_seven && c == CH_MINUS) begin
        f_minus = 1;
        return;
      end
      if (c == CH_POINT) begin
        if (f_point) f_bad = 1;
        f_point = 1;
        return;
      end
      if (c < CH_ZERO || c > CH_NINE) begin
        f_bad = 1;
        return;
      end
      f_digit = 1;
      // fraction digits past the kept count are checked only
      if (f_point && frac >= FRAC_DIGITS) return;
      if (!f_over) begin
        nxt = mag * 64'd10 + 64'(c - CH_ZERO);
        if (mag > MAG_MAX / 10 || nxt > MAG_MAX) f_over = 1;
        else mag = nxt;
      end
      if (f_point) frac++;
    endfunction

    function void note_byte(logic [7:0] c, logic is_last);
      result_t     r;
      logic [3:0]  p;
      logic [47:0] m;
      bit          syn;
      p = pos;
      // two-byte delay keeps CR LF out of the value
      if (p >= POS_SIGN_OUT) take_value_char(held_old, p == POS_SIGN_OUT);
      case (p)
        POS_START: if (c != CH_BSLASH) hdr_bad = 1;
        POS_OP: begin
          if (c == CH_W) op = OP_WRITE;
          else if (c == CH_R) op = OP_READ;
          else if (c == CH_P) op = OP_PRINT;
          else hdr_bad = 1;
        end
        POS_SEP: if (c != CH_USCORE) hdr_bad = 1;
        POS_ID0, POS_ID1, POS_ID2: id = {id[15:0], c};
        POS_EQ: if (op != OP_READ && c != CH_EQ) hdr_bad = 1;
        default: ;
      endcase
      if (!is_last) begin
        held_old = held_new;
        held_new = c;
        if (pos != POS_MAX) pos++;
        return;
      end
      syn = hdr_bad || p < POS_READ_END || held_new != CH_CR || c != CH_LF;
      if (!syn) syn = (op == OP_READ) ? (p != POS_READ_END) : (p < POS_SIGN_OUT);
      r = '0;
      if (syn) r.status = ST_SYNTAX;
      else if (op == OP_READ) r.status = ST_OK;
      else if (f_bad || f_over || !f_digit) r.status = ST_INVALID;
      else begin
        m = mag[47:0];
        if (f_minus) m = -m;
        r.status          = ST_OK;
        r.value_mantissa  = m;
        r.fraction_digits = 3'(frac);
        r.has_point       = f_point;
      end
      if (r.status == ST_OK) begin
        r.operation = op;
        r.param_id  = id;
      end
      expected_decodes.push_back(r);
      clear();
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
        mismatch_count++;
      end
    endfunction

    function void check_result(logic [1:0] st, logic [1:0] opr, logic [23:0] pid,
                               logic signed [47:0] mnt, logic [2:0] fd, logic fl);
      result_t want;
      if (expected_decodes.size() == 0) begin
        $display("%0t: result with none expected, status expected none got %0d",
                 $time, st);
        mismatch_count++;
        return;
      end
      want = expected_decodes.pop_front();
      compare_field("status", 64'(want.status), 64'(st));
      compare_field("operation", 64'(want.operation), 64'(opr));
      compare_field("param_id", 64'(want.param_id), 64'(pid));
      compare_field("value_mantissa", 64'(want.value_mantissa), 64'(mnt));
      compare_field("fraction_digits", 64'(want.fraction_digits), 64'(fd));
      compare_field("has_point", 64'(want.has_point), 64'(fl));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int   idle_pct;
  int   stall_cycles = 0;
  int   sent_bytes = 0;
  logic [7:0] frame_bytes[$];

  frame_decode_model decoder = new();

  tcfd_byte_if   cmd ();
  tcfd_result_if rsp ();

  text_command_frame_decoder i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  always #5 clk = ~clk;

  // result side backpressure
  always @(negedge clk) begin
    rsp.ready <= ($urandom_range(0, 99) >= idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready)
      decoder.check_result(rsp.status, rsp.operation, rsp.param_id,
                           rsp.value_mantissa, rsp.fraction_digits, rsp.has_point);
    if (rst || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // entered and left at a falling edge
  task automatic send_byte(logic [7:0] b, logic is_last);
    while ($urandom_range(0, 99) < idle_pct) begin
      cmd.valid <= 1'b0;
      @(negedge clk);
    end
    cmd.valid     <= 1'b1;
    cmd.data_byte <= b;
    cmd.last_byte <= is_last;
    do @(posedge clk); while (!cmd.ready);
    decoder.note_byte(b, is_last);
    @(negedge clk);
  endtask

  task automatic send_frame();
    int i;
    for (i = 0; i < frame_bytes.size(); i++)
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    sent_bytes += frame_bytes.size();
  endtask

  task automatic push_str(string s);
    int i;
    for (i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
  endtask

  task automatic push_digits(int n);
    repeat (n) frame_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic maybe_minus();
    if ($urandom_range(0, 1)) frame_bytes.push_back(CH_MINUS);
  endtask

  function automatic logic [7:0] other_than(logic [7:0] x);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == x);
    return b;
  endfunction

  task automatic build_value();
    case ($urandom_range(0, 11))
      0, 1, 2, 3, 4: begin
        maybe_minus();
        push_digits($urandom_range(1, 6));
        if ($urandom_range(0, 4) < 2) begin
          frame_bytes.push_back(CH_POINT);
          push_digits($urandom_range(0, 9));
        end
      end
      5: begin
        maybe_minus();
        frame_bytes.push_back(CH_POINT);
        push_digits($urandom_range(1, 8));
      end
      6, 10: begin
        // around the largest magnitude that fits
        maybe_minus();
        push_str("14073748835532");
        frame_bytes.push_back(CH_ZERO + 8'($urandom_range(5, 9)));
      end
      7: begin
        case ($urandom_range(0, 3))
          0: ;
          1: push_str("-");
          2: push_str(".");
          default: push_str("-.");
        endcase
      end
      8: begin
        maybe_minus();
        push_digits($urandom_range(1, 3));
        frame_bytes.push_back(CH_POINT);
      end
      9: begin
        maybe_minus();
        push_str("0.");
        push_digits($urandom_range(7, 12));
      end
      default: push_digits($urandom_range(15, 20));
    endcase
  endtask

  task automatic build_frame();
    int         op_sel;
    int         kind;
    int         at;
    logic [7:0] b;
    op_sel = $urandom_range(0, 2);
    frame_bytes = {};
    frame_bytes.push_back(CH_BSLASH);
    frame_bytes.push_back(op_sel == 0 ? CH_W : (op_sel == 1 ? CH_R : CH_P));
    frame_bytes.push_back(CH_USCORE);
    repeat (3) frame_bytes.push_back(8'($urandom_range(0, 255)));
    if (op_sel != 1) begin
      frame_bytes.push_back(CH_EQ);
      build_value();
    end
    frame_bytes.push_back(CH_CR);
    frame_bytes.push_back(CH_LF);
    kind = $urandom_range(0, 99);
    if (kind < 55) return;
    if (kind >= 88) begin
      frame_bytes = {};
      repeat ($urandom_range(1, 20)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    case ($urandom_range(0, 7))
      0: frame_bytes[0] = other_than(CH_BSLASH);
      1: begin
        do b = 8'($urandom_range(0, 255)); while (b == CH_W || b == CH_R || b == CH_P);
        frame_bytes[1] = b;
      end
      2: frame_bytes[2] = other_than(CH_USCORE);
      3: frame_bytes[6] = other_than(frame_bytes[6]);
      4: frame_bytes[frame_bytes.size() - 2] = other_than(CH_CR);
      5: frame_bytes[frame_bytes.size() - 1] = other_than(CH_LF);
      6: frame_bytes = frame_bytes[0:$urandom_range(0, frame_bytes.size() - 2)];
      default: begin
        // stray sign, point, digit or any byte inside the value
        case ($urandom_range(0, 3))
          0: b = CH_MINUS;
          1: b = CH_POINT;
          2: b = CH_ZERO + 8'($urandom_range(0, 9));
          default: b = 8'($urandom_range(0, 255));
        endcase
        at = $urandom_range(7, frame_bytes.size() - 2);
        frame_bytes.insert(at, b);
      end
    endcase
  endtask

  initial begin
    int frame_no;
    rst           = 1'b1;
    idle_pct      = IDLE_PCT;
    cmd.valid     = 1'b0;
    cmd.data_byte = '0;
    cmd.last_byte = 1'b0;
    rsp.ready     = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // single-byte frame, read with extreme id bytes, negative print float
    frame_bytes = {CH_BSLASH};
    send_frame();
    frame_bytes = {CH_BSLASH, CH_R, CH_USCORE, 8'h00, 8'hFF, 8'h5A, CH_CR, CH_LF};
    send_frame();
    frame_bytes = {};
    push_str("\\p_abc=-1.5");
    frame_bytes.push_back(CH_CR);
    frame_bytes.push_back(CH_LF);
    send_frame();

    frame_no = 0;
    while (sent_bytes < TOTAL_BYTES) begin
      idle_pct = (frame_no >= 20 && frame_no < 40) ? 0 : IDLE_PCT;
      build_frame();
      send_frame();
      frame_no++;
    end
    cmd.valid <= 1'b0;
    idle_pct = IDLE_PCT;

    while (decoder.expected_decodes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (decoder.mismatch_count == 0 && decoder.expected_decodes.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
